>>> rtl/core/dtb_pkg.sv
// ----------------------------------------------------------------------------
// dtb_pkg
// Widths, register indexes and shared types of the dual token bucket limiter.
// ----------------------------------------------------------------------------
package dtb_pkg;

	localparam int TS_W   = 48;   // time stamp
	localparam int CNT_W  = 32;   // request counts
	localparam int AMT_W  = 32;   // refill amount
	localparam int TOK_W  = 48;   // bucket contents and maxima
	localparam int CFG_W  = 48;   // config write data
	localparam int PER_W  = 21;   // refill period, up to 2^20
	localparam int Q1_W   = 49;   // period index plus one, up to 2^48
	localparam int PROD_W = Q1_W + AMT_W;

	localparam int unsigned REFILL_PERIOD_DEF = 1024;

	localparam logic [TOK_W-1:0] TOK_MAX = {TOK_W{1'b1}};

	// cycles a refill amount write holds off requests while M*amount is rebuilt
	localparam logic [1:0] RESC_LAT = 2'd3;

	typedef enum logic [1:0] {
		REG_OP_AMT = 2'd0,
		REG_OP_MAX = 2'd1,
		REG_BY_AMT = 2'd2,
		REG_BY_MAX = 2'd3
	} dtb_reg_t;

	// quotient of the time stamp by the period, with derived flags
	typedef struct packed {
		logic [Q1_W-1:0] q1;       // floor(now / period) + 1
		logic            ovf;      // q1 * period exceeds the time range
		logic            now_max;  // time stamp is all ones
	} dtb_time_t;

	// per request control into both buckets
	typedef struct packed {
		logic upd;     // request passes the state stage
		logic refill;  // refill happens for this request
		logic sat;     // refill time already saturated
	} dtb_step_t;

endpackage

>>> rtl/core/dual_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// dual_token_bucket_limiter
// Admits requests against an operation bucket and a byte bucket.
// ----------------------------------------------------------------------------
// Requests (now_us, op_count, byte_count) enter on in_valid/in_ready; each
// yields one grant bit on out_valid/out_ready, in request order.
// One request is taken per cycle unless a stall or a product rebuild holds
// in_ready low. The time stamp is divided by the period through a reciprocal
// multiply and a correction step, and (Q+1) * amount is formed in a 2-step
// multiplier; only the bucket update itself sits in the request-to-request
// loop, so the refill period index and its product are kept as state.
// Writing a refill amount holds in_ready low while the stored M * amount
// product is rebuilt.
// A stalled receiver fills the 7 stages and the output register; in_ready
// drops when the stage behind it cannot move or while a product is rebuilt.
// Reset clears the valid flags, the configuration, both buckets and the refill time; a refill
// amount of zero turns its bucket off, and with both off every request is
// granted.
// ----------------------------------------------------------------------------
module dual_token_bucket_limiter #(
	parameter int unsigned REFILL_PERIOD_US = dtb_pkg::REFILL_PERIOD_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dtb_pkg::TS_W-1:0]   now_us,
	input  logic [dtb_pkg::CNT_W-1:0]  op_count,
	input  logic [dtb_pkg::CNT_W-1:0]  byte_count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       granted,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_idx,
	input  logic [dtb_pkg::CFG_W-1:0]  cfg_wdata
);
	import dtb_pkg::*;

	logic [AMT_W-1:0] op_amt_q, by_amt_q;
	logic [TOK_W-1:0] op_max_q, by_max_q;

	logic [8:1]       en;
	logic [7:1]       vld_q;
	logic             out_vld_q;
	logic             gnt_q;
	logic             in_go;

	logic [CNT_W-1:0] opc_s [1:7];
	logic [CNT_W-1:0] byc_s [1:7];

	dtb_time_t        tm_s5, tm_s6, tm_s7;
	logic [PROD_W-1:0] op_qa1_s7, by_qa1_s7;

	logic [Q1_W-1:0]  m_q;
	logic             sat_q;
	logic [1:0]       resc_cnt_q;
	logic             resc_busy;
	logic [PROD_W-1:0] op_ma, by_ma;

	logic             op_on, by_on, any_on;
	logic             refill, ok;
	logic             op_enough, by_enough;
	dtb_step_t        step;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_amt_q <= '0;
			op_max_q <= '0;
			by_amt_q <= '0;
			by_max_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_OP_AMT: op_amt_q <= cfg_wdata[AMT_W-1:0];
				REG_OP_MAX: op_max_q <= cfg_wdata[TOK_W-1:0];
				REG_BY_AMT: by_amt_q <= cfg_wdata[AMT_W-1:0];
				REG_BY_MAX: by_max_q <= cfg_wdata[TOK_W-1:0];
				default: ;
			endcase
		end
	end

	// rebuild M * amount after an amount write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resc_cnt_q <= '0;
		end else if (cfg_we && (cfg_idx == REG_OP_AMT || cfg_idx == REG_BY_AMT)) begin
			resc_cnt_q <= RESC_LAT;
		end else if (resc_busy) begin
			resc_cnt_q <= resc_cnt_q - 2'd1;
		end
	end

	assign resc_busy = resc_cnt_q != '0;

	dtb_mul u_op_resc (
		.clk    (clk),
		.en_pp  (resc_busy),
		.en_sum (resc_busy),
		.a      (m_q),
		.b      (op_amt_q),
		.p      (op_ma)
	);

	dtb_mul u_by_resc (
		.clk    (clk),
		.en_pp  (resc_busy),
		.en_sum (resc_busy),
		.a      (m_q),
		.b      (by_amt_q),
		.p      (by_ma)
	);

	// stage flow
	always_comb begin
		en[8] = !out_vld_q || out_ready;
		for (int k = 7; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign in_ready = en[1] && !resc_busy;
	assign in_go    = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_go;
			end
			for (int k = 2; k <= 7; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
			if (en[8]) begin
				out_vld_q <= vld_q[7];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			opc_s[1] <= op_count;
			byc_s[1] <= byte_count;
		end
		for (int k = 2; k <= 7; k++) begin
			if (en[k]) begin
				opc_s[k] <= opc_s[k-1];
				byc_s[k] <= byc_s[k-1];
			end
		end
		if (en[6]) begin
			tm_s6 <= tm_s5;
		end
		if (en[7]) begin
			tm_s7 <= tm_s6;
		end
	end

	dtb_quot #(
		.REFILL_PERIOD_US (REFILL_PERIOD_US)
	) u_quot (
		.clk (clk),
		.en  (en[5:1]),
		.now (now_us),
		.tm  (tm_s5)
	);

	dtb_mul u_op_mul (
		.clk    (clk),
		.en_pp  (en[6]),
		.en_sum (en[7]),
		.a      (tm_s5.q1),
		.b      (op_amt_q),
		.p      (op_qa1_s7)
	);

	dtb_mul u_by_mul (
		.clk    (clk),
		.en_pp  (en[6]),
		.en_sum (en[7]),
		.a      (tm_s5.q1),
		.b      (by_amt_q),
		.p      (by_qa1_s7)
	);

	// state stage
	assign op_on  = |op_amt_q;
	assign by_on  = |by_amt_q;
	assign any_on = op_on || by_on;
	assign refill = any_on && (sat_q ? tm_s7.now_max : (tm_s7.q1 > m_q));
	assign ok     = (!op_on || op_enough) && (!by_on || by_enough);

	assign step.upd    = en[8] && vld_q[7];
	assign step.refill = refill;
	assign step.sat    = sat_q;

	dtb_bucket u_op_bkt (
		.clk     (clk),
		.arst_n  (arst_n),
		.amount  (op_amt_q),
		.limit   (op_max_q),
		.qa1     (op_qa1_s7),
		.resc_ld (resc_cnt_q == 2'd1),
		.resc_p  (op_ma),
		.ctl     (step),
		.take    (ok && op_on),
		.need    (opc_s[7]),
		.enough  (op_enough)
	);

	dtb_bucket u_by_bkt (
		.clk     (clk),
		.arst_n  (arst_n),
		.amount  (by_amt_q),
		.limit   (by_max_q),
		.qa1     (by_qa1_s7),
		.resc_ld (resc_cnt_q == 2'd1),
		.resc_p  (by_ma),
		.ctl     (step),
		.take    (ok && by_on),
		.need    (byc_s[7]),
		.enough  (by_enough)
	);

	// next refill time is m_q * period until it saturates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q   <= '0;
			sat_q <= 1'b0;
			gnt_q <= 1'b0;
		end else if (step.upd) begin
			gnt_q <= ok;
			if (refill && !sat_q) begin
				m_q <= tm_s7.q1;
				if (tm_s7.ovf) begin
					sat_q <= 1'b1;
				end
			end
		end
	end

	assign out_valid = out_vld_q;
	assign granted   = gnt_q;

	a_resc_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		resc_busy |-> !in_ready)
		else $error("request accepted during product rebuild");

	a_all_off_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(step.upd && !any_on) |=> gnt_q)
		else $error("request refused with both buckets off");

	a_sat_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |=> sat_q)
		else $error("refill time left saturation");

	a_m_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(step.upd && refill && !sat_q) |=> (m_q > $past(m_q)))
		else $error("refill time did not advance");

endmodule

>>> rtl/core/dtb_mul.sv
// ----------------------------------------------------------------------------
// dtb_mul
// 49 x 32 multiplier in two registered steps: partial products, then sum.
// ----------------------------------------------------------------------------
module dtb_mul (
	input  logic                        clk,
	input  logic                        en_pp,
	input  logic                        en_sum,
	input  logic [dtb_pkg::Q1_W-1:0]    a,
	input  logic [dtb_pkg::AMT_W-1:0]   b,
	output logic [dtb_pkg::PROD_W-1:0]  p
);
	import dtb_pkg::*;

	localparam int LO_W = 25;
	localparam int HI_W = Q1_W - LO_W;

	logic [LO_W+AMT_W-1:0] pp_lo_q;
	logic [HI_W+AMT_W-1:0] pp_hi_q;

	always_ff @(posedge clk) begin
		if (en_pp) begin
			pp_lo_q <= (LO_W+AMT_W)'(a[LO_W-1:0]) * (LO_W+AMT_W)'(b);
			pp_hi_q <= (HI_W+AMT_W)'(a[Q1_W-1:LO_W]) * (HI_W+AMT_W)'(b);
		end
		if (en_sum) begin
			p <= PROD_W'(pp_lo_q) + (PROD_W'(pp_hi_q) << LO_W);
		end
	end

endmodule

>>> rtl/core/dtb_quot.sv
// ----------------------------------------------------------------------------
// dtb_quot
// Time stamp divided by the refill period: reciprocal multiply, one-step
// correction, then overflow flag for the next refill time.
// ----------------------------------------------------------------------------
module dtb_quot #(
	parameter int unsigned REFILL_PERIOD_US = dtb_pkg::REFILL_PERIOD_DEF
) (
	input  logic                      clk,
	input  logic [4:0]                en,   // capture enables, stage 1 in bit 0
	input  logic [dtb_pkg::TS_W-1:0]  now,
	output dtb_pkg::dtb_time_t        tm
);
	import dtb_pkg::*;

	localparam int H = TS_W / 2;
	localparam logic [Q1_W-1:0]  RECIP = Q1_W'((64'd1 << TS_W) / 64'(REFILL_PERIOD_US));
	localparam logic [PER_W-1:0] PER   = PER_W'(REFILL_PERIOD_US);
	localparam logic [TS_W-1:0]  QMAX  = TS_W'(64'(TOK_MAX) / 64'(REFILL_PERIOD_US));
	localparam int PLL_W = 2 * H;
	localparam int PLH_W = H + Q1_W - H;
	localparam int QT_W  = H + PER_W;
	localparam int ACC_W = 2 * TS_W + 1;

	logic [TS_W-1:0]  now_s1, now_s2, now_s3, now_s4;
	logic [PLL_W-1:0] pp_ll_s2, pp_hl_s2;
	logic [PLH_W-1:0] pp_lh_s2, pp_hh_s2;
	logic [TS_W-1:0]  q0_s3, q0_s4;
	logic [QT_W-1:0]  qt_lo_s4, qt_hi_s4;
	logic [TS_W-1:0]  q_s5;
	logic             nowmax_s5;

	logic [ACC_W-1:0]    acc;
	logic [QT_W+H-1:0]   qt;
	logic [TS_W-1:0]     rem;
	logic                adj;

	// estimate is floor(now / period) or one less
	assign acc = ACC_W'(pp_ll_s2) + (ACC_W'(pp_lh_s2) << H) + (ACC_W'(pp_hl_s2) << H)
		+ (ACC_W'(pp_hh_s2) << TS_W);

	assign qt  = ((QT_W+H)'(qt_hi_s4) << H) + (QT_W+H)'(qt_lo_s4);
	assign rem = now_s4 - qt[TS_W-1:0];
	assign adj = rem >= TS_W'(PER);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			now_s1 <= now;
		end
		if (en[1]) begin
			now_s2   <= now_s1;
			pp_ll_s2 <= PLL_W'(now_s1[H-1:0]) * PLL_W'(RECIP[H-1:0]);
			pp_lh_s2 <= PLH_W'(now_s1[H-1:0]) * PLH_W'(RECIP[Q1_W-1:H]);
			pp_hl_s2 <= PLL_W'(now_s1[TS_W-1:H]) * PLL_W'(RECIP[H-1:0]);
			pp_hh_s2 <= PLH_W'(now_s1[TS_W-1:H]) * PLH_W'(RECIP[Q1_W-1:H]);
		end
		if (en[2]) begin
			now_s3 <= now_s2;
			q0_s3  <= acc[2*TS_W-1:TS_W];
		end
		if (en[3]) begin
			now_s4   <= now_s3;
			q0_s4    <= q0_s3;
			qt_lo_s4 <= QT_W'(q0_s3[H-1:0]) * QT_W'(PER);
			qt_hi_s4 <= QT_W'(q0_s3[TS_W-1:H]) * QT_W'(PER);
		end
		if (en[4]) begin
			q_s5      <= q0_s4 + TS_W'(adj);
			nowmax_s5 <= &now_s4;
		end
	end

	assign tm.q1      = Q1_W'(q_s5) + Q1_W'(1);
	assign tm.ovf     = q_s5 >= QMAX;
	assign tm.now_max = nowmax_s5;

endmodule

>>> rtl/core/dtb_bucket.sv
// ----------------------------------------------------------------------------
// dtb_bucket
// One token bucket: refill with saturation and clamp, check, take.
// ----------------------------------------------------------------------------
module dtb_bucket (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [dtb_pkg::AMT_W-1:0]   amount,
	input  logic [dtb_pkg::TOK_W-1:0]   limit,
	input  logic [dtb_pkg::PROD_W-1:0]  qa1,      // (Q+1) * amount of this request
	input  logic                        resc_ld,
	input  logic [dtb_pkg::PROD_W-1:0]  resc_p,   // M * amount after an amount write
	input  dtb_pkg::dtb_step_t          ctl,
	input  logic                        take,
	input  logic [dtb_pkg::CNT_W-1:0]   need,
	output logic                        enough
);
	import dtb_pkg::*;

	logic [TOK_W-1:0]  tok_q;
	logic [PROD_W-1:0] ma_q;     // M * amount, M = period index of next refill

	logic [PROD_W-1:0] diff;
	logic              gain_big;
	logic [TOK_W-1:0]  gain;
	logic [TOK_W:0]    sum;
	logic [TOK_W-1:0]  sum_sat;
	logic [TOK_W-1:0]  tok_cl;
	logic [TOK_W-1:0]  tok_ref;

	// periods * amount = (Q+1)*amount - M*amount
	assign diff     = qa1 - ma_q;
	assign gain_big = !ctl.sat && (|diff[PROD_W-1:TOK_W]);
	assign gain     = ctl.sat ? TOK_W'(amount) : diff[TOK_W-1:0];
	assign sum      = (TOK_W+1)'(tok_q) + (TOK_W+1)'(gain);
	assign sum_sat  = (gain_big || sum[TOK_W]) ? TOK_MAX : sum[TOK_W-1:0];
	assign tok_cl   = (sum_sat < limit) ? sum_sat : limit;
	assign tok_ref  = ctl.refill ? tok_cl : tok_q;
	assign enough   = TOK_W'(need) <= tok_ref;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
			ma_q  <= '0;
		end else begin
			if (ctl.upd) begin
				tok_q <= take ? tok_ref - TOK_W'(need) : tok_ref;
			end
			if (resc_ld) begin
				ma_q <= resc_p;
			end else if (ctl.upd && ctl.refill && !ctl.sat) begin
				ma_q <= qa1;
			end
		end
	end

endmodule
